// File: sv/kdb_pkg.sv
package kdb_pkg;

  // lanes per scanned byte, one per key bit
  localparam int unsigned LaneCnt   = 8;
  localparam int unsigned LaneIdxW  = 3;
  localparam int unsigned CntW      = 8;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned ChanW     = 5;
  localparam int unsigned VelW      = 7;
  localparam int unsigned ByteIdxW  = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;

  localparam int unsigned DefNumKeys = 64;

  localparam logic [CntW-1:0] CntMax = 8'hFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgChannel  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVelocity = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffset   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOnDelay  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOffDelay = 3'd4;

  // reset values of the configuration registers
  localparam logic [ChanW-1:0] RstChannel  = 5'd1;
  localparam logic [VelW-1:0]  RstVelocity = 7'd64;
  localparam logic [NoteW-1:0] RstOffset   = 7'd36;
  localparam logic [CntW-1:0]  RstOnDelay  = 8'd3;
  localparam logic [CntW-1:0]  RstOffDelay = 8'd3;

  // what the lanes found for one byte, handed to the event stage
  typedef struct packed {
    logic [LaneCnt-1:0] ev_mask;
    logic [LaneCnt-1:0] on_bits;
    logic [NoteW-1:0]   note_base;
    logic [ChanW-1:0]   channel;
    logic [VelW-1:0]    velocity;
  } byte_ev_t;

endpackage

// File: sv/kdb_lane.sv
module kdb_lane (
  input  logic                      pressed_i,
  input  logic                      on_i,
  input  logic [kdb_pkg::CntW-1:0]  cnt_i,
  input  logic [kdb_pkg::CntW-1:0]  on_delay_i,
  input  logic [kdb_pkg::CntW-1:0]  off_delay_i,
  output logic                      on_o,
  output logic [kdb_pkg::CntW-1:0]  cnt_o,
  output logic                      changed_o
);
  import kdb_pkg::*;

  logic [CntW-1:0] limit;
  logic [CntW-1:0] cnt_inc;

  assign limit   = on_i ? off_delay_i : on_delay_i;
  // saturating streak count
  assign cnt_inc = (cnt_i == CntMax) ? CntMax : cnt_i + 8'd1;

  // one debounce step for a single key
  always_comb begin
    on_o      = on_i;
    cnt_o     = cnt_inc;
    changed_o = 1'b0;
    if (pressed_i == on_i) begin
      cnt_o = '0;
    end else if (cnt_inc >= limit) begin
      cnt_o     = '0;
      on_o      = ~on_i;
      changed_o = 1'b1;
    end
  end

endmodule

// File: sv/kdb_merge.sv
module kdb_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_valid_i,
  output logic                         load_ready_o,
  input  kdb_pkg::byte_ev_t            load_ev_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         is_note_on_o,
  output logic [kdb_pkg::NoteW-1:0]    note_number_o,
  output logic [kdb_pkg::ChanW-1:0]    channel_out_o,
  output logic [kdb_pkg::VelW-1:0]     velocity_out_o,
  output logic                         last_event_o
);
  import kdb_pkg::*;

  byte_ev_t            pend_q, pend_d;
  logic [LaneCnt-1:0]  lowest;
  logic [LaneIdxW-1:0] low_idx;
  logic                single;
  logic                out_fire;
  logic                load;

  // lowest pending event goes out first
  assign lowest = pend_q.ev_mask & (~pend_q.ev_mask + 8'd1);
  assign single = (pend_q.ev_mask & (pend_q.ev_mask - 8'd1)) == '0;

  always_comb begin
    low_idx = '0;
    for (int i = LaneCnt - 1; i >= 0; i--) begin
      if (pend_q.ev_mask[i]) begin
        low_idx = LaneIdxW'(i);
      end
    end
  end

  assign out_valid_o  = pend_q.ev_mask != '0;
  assign out_fire     = out_valid_o & ~out_stall_i;
  assign load_ready_o = ~out_valid_o | (single & ~out_stall_i);
  assign load         = load_valid_i & load_ready_o;

  assign is_note_on_o   = pend_q.on_bits[low_idx];
  assign note_number_o  = pend_q.note_base + {{(NoteW-LaneIdxW){1'b0}}, low_idx};
  assign channel_out_o  = pend_q.channel;
  assign velocity_out_o = pend_q.velocity;
  assign last_event_o   = single;

  // take a new byte or retire the event just sent
  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d = load_ev_i;
    end else if (out_fire) begin
      pend_d.ev_mask = pend_q.ev_mask & ~lowest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

`ifndef SYNTHESIS
  // no new byte while events of the current one remain
  a_no_load_midbyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_ready_o |-> (!out_valid_o || (last_event_o && !out_stall_i)))
    else $error("byte taken while events still pending");

  // a non-final event leaves more behind
  a_more_after_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_event_o) |=> out_valid_o)
    else $error("events lost after a non-final event");

  // a byte with transitions shows an event next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (load_ev_i.ev_mask != '0)) |=> out_valid_o)
    else $error("loaded events not presented");
`endif

endmodule

// File: sv/key_bank_debounce_note_events_unit.sv
// Key bank debouncer: takes one scanned byte (index plus eight pressed flags)
// per transaction and emits a note-on or note-off event for each key that
// actually changes state, lowest bit first, with last_event_o marking the
// final event of the byte. Eight debounce lanes update a whole byte of keys
// in the cycle it is accepted; an event register then hands the events out
// one per cycle while out_stall_i is low, the first in the cycle after the
// byte is taken. The next byte is taken in the cycle the last event of the
// previous one leaves, so bytes with no or one transition stream at one per
// clock while out_stall_i is low. At reset key state clears and the config
// registers take their reset values; no sweep.
// Configuration writes are always accepted (cfg_ready_o is tied high);
// indexes 0..4 are channel, velocity, note offset, on delay, off delay.
module key_bank_debounce_note_events_unit #(
  parameter int unsigned NUM_KEYS = kdb_pkg::DefNumKeys
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kdb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kdb_pkg::CfgDataW-1:0]  cfg_data_i,
  // scanned bytes
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kdb_pkg::ByteIdxW-1:0]  byte_index_i,
  input  logic [kdb_pkg::LaneCnt-1:0]   key_bits_i,
  // note events
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_note_on_o,
  output logic [kdb_pkg::NoteW-1:0]     note_number_o,
  output logic [kdb_pkg::ChanW-1:0]     channel_out_o,
  output logic [kdb_pkg::VelW-1:0]      velocity_out_o,
  output logic                          last_event_o
);
  import kdb_pkg::*;

  localparam int unsigned NumRows = (NUM_KEYS + LaneCnt - 1) / LaneCnt;
  localparam int unsigned RowW    = (NumRows > 1) ? $clog2(NumRows) : 1;

  // configuration registers
  logic [ChanW-1:0] channel_q;
  logic [VelW-1:0]  velocity_q;
  logic [NoteW-1:0] offset_q;
  logic [CntW-1:0]  on_delay_q;
  logic [CntW-1:0]  off_delay_q;

  logic cfg_fire;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q   <= RstChannel;
      velocity_q  <= RstVelocity;
      offset_q    <= RstOffset;
      on_delay_q  <= RstOnDelay;
      off_delay_q <= RstOffDelay;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CfgChannel:  channel_q   <= cfg_data_i[ChanW-1:0];
        CfgVelocity: velocity_q  <= cfg_data_i[VelW-1:0];
        CfgOffset:   offset_q    <= cfg_data_i[NoteW-1:0];
        CfgOnDelay:  on_delay_q  <= cfg_data_i;
        CfgOffDelay: off_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-key state, one row of eight keys per byte index
  logic [LaneCnt-1:0] on_q  [NumRows];
  logic [CntW-1:0]    cnt_q [NumRows][LaneCnt];

  logic               accept;
  logic               merge_ready;
  logic               row_hit;
  logic [RowW-1:0]    row_sel;
  logic [LaneCnt-1:0] lane_ok;
  logic [LaneCnt-1:0] lane_on;
  logic [LaneCnt-1:0] lane_chg;
  logic [CntW-1:0]    lane_cnt [LaneCnt];
  byte_ev_t           ev;

  assign in_stall_o = ~merge_ready;
  assign accept     = in_valid_i & merge_ready;
  assign row_hit    = {4'b0, byte_index_i} < 8'(NumRows);
  assign row_sel    = row_hit ? byte_index_i[RowW-1:0] : '0;

  // debounce lanes
  for (genvar b = 0; b < LaneCnt; b++) begin : g_lane
    assign lane_ok[b] = {1'b0, byte_index_i, 3'(b)} < 8'(NUM_KEYS);

    kdb_lane u_lane (
      .pressed_i   (key_bits_i[b]),
      .on_i        (on_q[row_sel][b]),
      .cnt_i       (cnt_q[row_sel][b]),
      .on_delay_i  (on_delay_q),
      .off_delay_i (off_delay_q),
      .on_o        (lane_on[b]),
      .cnt_o       (lane_cnt[b]),
      .changed_o   (lane_chg[b])
    );
  end

  // write back the lanes' results for in-range keys
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        on_q[r] <= '0;
        for (int b = 0; b < LaneCnt; b++) begin
          cnt_q[r][b] <= '0;
        end
      end
    end else if (accept) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int b = 0; b < LaneCnt; b++) begin
          if (lane_ok[b] && row_sel == RowW'(r)) begin
            on_q[r][b]  <= lane_on[b];
            cnt_q[r][b] <= lane_cnt[b];
          end
        end
      end
    end
  end

  // gather the byte's transitions for the event stage
  always_comb begin
    ev.ev_mask   = lane_chg & lane_ok;
    ev.on_bits   = lane_on;
    ev.note_base = offset_q + {byte_index_i, 3'b000};
    ev.channel   = channel_q;
    ev.velocity  = velocity_q;
  end

  kdb_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_valid_i   (in_valid_i),
    .load_ready_o   (merge_ready),
    .load_ev_i      (ev),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_note_on_o   (is_note_on_o),
    .note_number_o  (note_number_o),
    .channel_out_o  (channel_out_o),
    .velocity_out_o (velocity_out_o),
    .last_event_o   (last_event_o)
  );

endmodule
